// File: hw/rtl/jrdz_pkg.sv
// ----------------------------------------------------------------------------
// jrdz_pkg
// Shared types and codes for the joystick radial dead zone unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jrdz_pkg;

   // Result zone codes
   typedef enum logic [1:0] {
      ZONE_DEAD = 2'd0,
      ZONE_BAND = 2'd1,
      ZONE_FULL = 2'd2
   } zone_type;

   // Configuration register indexes
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_INNER_THRESHOLD = 1'b0;
   localparam csr_index_type CSR_OUTER_THRESHOLD = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/jrdz_if.sv
// ----------------------------------------------------------------------------
// jrdz_if
// Valid/ready channels for stick samples and corrected results.
// ----------------------------------------------------------------------------
`default_nettype none

interface jrdz_req_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] raw_x;
   logic signed [W-1:0] raw_y;

   modport source (output valid, raw_x, raw_y, input ready);
   modport sink   (input valid, raw_x, raw_y, output ready);
endinterface

interface jrdz_rsp_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] corrected_x;
   logic signed [W-1:0] corrected_y;
   logic        [W-1:0] corrected_magnitude;
   jrdz_pkg::zone_type  zone;

   modport source (output valid, corrected_x, corrected_y, corrected_magnitude, zone,
                   input ready);
   modport sink   (input valid, corrected_x, corrected_y, corrected_magnitude, zone,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/jrdz_sqrt_cell.sv
// ----------------------------------------------------------------------------
// jrdz_sqrt_cell
// One bit of a pipelined integer square root: tries setting root bit BIT.
// ----------------------------------------------------------------------------
`default_nettype none

module jrdz_sqrt_cell #(
   parameter int W     = 16,
   parameter int BIT   = 0,
   parameter int TAG_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [TAG_W-1:0] in_tag,
   input  wire logic [2*W-1:0]   in_rem,
   input  wire logic [W-1:0]     in_root,
   output logic                  out_valid,
   output logic      [TAG_W-1:0] out_tag,
   output logic      [2*W-1:0]   out_rem,
   output logic      [W-1:0]     out_root
);
   localparam logic [2*W:0] SQ_BIT = (2*W+1)'(1) << (2*BIT);

   logic           valid_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [2*W-1:0] rem_ff, rem_in;
   logic [W-1:0]   root_ff, root_in;
   logic [2*W:0]   trial;

   // trial = (2*root + 2^BIT) * 2^BIT, the growth of root^2 if this bit is set
   always_comb begin
      trial = (((2*W+1)'(in_root)) << (BIT + 1)) | SQ_BIT;
      if ({1'b0, in_rem} >= trial) begin
         rem_in  = in_rem - trial[2*W-1:0];
         root_in = in_root | (W'(1) << BIT);
      end else begin
         rem_in  = in_rem;
         root_in = in_root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff  <= in_tag;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
endmodule

`default_nettype wire

// File: hw/rtl/jrdz_div_cell.sv
// ----------------------------------------------------------------------------
// jrdz_div_cell
// One quotient bit of a restoring divider, for LANES numerators sharing a
// divisor. Quotient is known to fit W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module jrdz_div_cell #(
   parameter int W     = 16,
   parameter int LANES = 1,
   parameter int TAG_W = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [TAG_W-1:0]           in_tag,
   input  wire logic [W-1:0]               in_div,
   input  wire logic [LANES-1:0][W-1:0]    in_rem,
   input  wire logic [LANES-1:0][W-1:0]    in_lo,
   input  wire logic [LANES-1:0][W-1:0]    in_quot,
   output logic                            out_valid,
   output logic      [TAG_W-1:0]           out_tag,
   output logic      [W-1:0]               out_div,
   output logic      [LANES-1:0][W-1:0]    out_rem,
   output logic      [LANES-1:0][W-1:0]    out_lo,
   output logic      [LANES-1:0][W-1:0]    out_quot
);
   logic                    valid_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic [W-1:0]            div_ff;
   logic [LANES-1:0][W-1:0] rem_ff, rem_in;
   logic [LANES-1:0][W-1:0] lo_ff, lo_in;
   logic [LANES-1:0][W-1:0] quot_ff, quot_in;
   logic [LANES-1:0][W:0]   shifted;
   logic [LANES-1:0]        fits;

   // Shift in the next numerator bit, subtract when the divisor fits
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         shifted[i] = {in_rem[i], in_lo[i][W-1]};
         fits[i]    = shifted[i] >= {1'b0, in_div};
         rem_in[i]  = fits[i] ? W'(shifted[i] - {1'b0, in_div}) : shifted[i][W-1:0];
         lo_in[i]   = in_lo[i] << 1;
         quot_in[i] = {in_quot[i][W-2:0], fits[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff  <= in_tag;
         div_ff  <= in_div;
         rem_ff  <= rem_in;
         lo_ff   <= lo_in;
         quot_ff <= quot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;
   assign out_lo    = lo_ff;
   assign out_quot  = quot_ff;
endmodule

`default_nettype wire

// File: hw/rtl/joystick_radial_dead_zone_unit.sv
// ----------------------------------------------------------------------------
// joystick_radial_dead_zone_unit
// Scaled radial dead zone for an analog stick sample (x, y).
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one raw (x, y) sample per beat; rsp_chan returns one
//   corrected (x, y), the rescaled radius and the zone per beat, in order.
//   csr_* writes the inner (index 0) and outer (index 1) thresholds; write
//   them only while no sample is in flight.
// Timing:
//   The pipeline is one bit-cell chain each for the square root of x^2+y^2,
//   the scale division and the x/y divisions by the radius, plus input,
//   squaring, zone, multiply and output registers.
//   Throughput is one sample per cycle while rsp_chan does not stall.
// Reset:
//   Synchronous reset empties the pipeline and loads thresholds of 0.30 and
//   0.95 of full scale.
// Stall:
//   When rsp_chan is held not ready with a result waiting, the whole chain
//   freezes and req_chan.ready drops until the result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_radial_dead_zone_unit #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   jrdz_req_if.sink                        req_chan,
   jrdz_rsp_if.source                      rsp_chan,
   input  wire logic                       csr_we,
   input  wire jrdz_pkg::csr_index_type    csr_index,
   input  wire logic [SAMPLE_BITS-1:0]     csr_wdata
);
   import jrdz_pkg::*;

   localparam int W = SAMPLE_BITS;
   localparam longint ONE_L = longint'(1) << (W - 1);
   localparam logic [W-1:0] ONE       = W'(ONE_L);
   localparam logic [W-1:0] INNER_RST = W'((3 * ONE_L + 5) / 10);
   localparam logic [W-1:0] OUTER_RST = W'((19 * ONE_L + 10) / 20);
   localparam int SQ_TAG_W = 4 * W;
   localparam int S_TAG_W  = 3 * W + 3;
   localparam int XY_TAG_W = W + 5;

   logic en;

   // Threshold registers
   logic [W-1:0] inner_ff, outer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= INNER_RST;
         outer_ff <= OUTER_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INNER_THRESHOLD: inner_ff <= csr_wdata;
            CSR_OUTER_THRESHOLD: outer_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Whole chain advances unless a result is waiting on a stalled receiver
   logic rsp_valid_ff;
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Input register
   logic         v0_ff;
   logic [W-1:0] x0_ff, y0_ff, in0_ff, out0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff   <= req_chan.raw_x;
         y0_ff   <= req_chan.raw_y;
         in0_ff  <= inner_ff;
         out0_ff <= outer_ff;
      end
   end

   // Sum of squares
   logic           v1_ff;
   logic [2*W-1:0] sq1_ff, sq1_in;
   logic [W-1:0]   x1_ff, y1_ff, in1_ff, out1_ff;
   logic signed [2*W-1:0] xx, yy;

   always_comb begin
      xx     = $signed(x0_ff) * $signed(x0_ff);
      yy     = $signed(y0_ff) * $signed(y0_ff);
      sq1_in = xx + yy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq1_ff  <= sq1_in;
         x1_ff   <= x0_ff;
         y1_ff   <= y0_ff;
         in1_ff  <= in0_ff;
         out1_ff <= out0_ff;
      end
   end

   // Square root chain, one root bit per cell, MSB first
   logic                sq_v   [W+1];
   logic [SQ_TAG_W-1:0] sq_tag [W+1];
   logic [2*W-1:0]      sq_rem [W+1];
   logic [W-1:0]        sq_root[W+1];

   assign sq_v[0]    = v1_ff;
   assign sq_tag[0]  = {x1_ff, y1_ff, in1_ff, out1_ff};
   assign sq_rem[0]  = sq1_ff;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < W; k++) begin : g_sqrt
      jrdz_sqrt_cell #(.W(W), .BIT(W - 1 - k), .TAG_W(SQ_TAG_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (sq_v[k]),
         .in_tag   (sq_tag[k]),
         .in_rem   (sq_rem[k]),
         .in_root  (sq_root[k]),
         .out_valid(sq_v[k+1]),
         .out_tag  (sq_tag[k+1]),
         .out_rem  (sq_rem[k+1]),
         .out_root (sq_root[k+1])
      );
   end

   // Zone decision and scale division setup
   logic [W-1:0]   m2, x2, y2, in2, out2, diff2;
   logic [2*W-1:0] num2;
   zone_type       zone2;

   always_comb begin
      {x2, y2, in2, out2} = sq_tag[W];
      m2 = sq_root[W];
      if (m2 < in2) begin
         zone2 = ZONE_DEAD;
      end else if (m2 > out2) begin
         zone2 = ZONE_FULL;
      end else begin
         zone2 = ZONE_BAND;
      end
      diff2 = m2 - in2;
      num2  = {1'b0, diff2, {(W-1){1'b0}}};
   end

   logic               v3_ff;
   logic [S_TAG_W-1:0] tag3_ff;
   logic [W-1:0]       div3_ff, rem3_ff, lo3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= sq_v[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag3_ff <= {x2, y2, m2, zone2, (out2 == in2)};
         div3_ff <= out2 - in2;
         rem3_ff <= num2[2*W-1:W];
         lo3_ff  <= num2[W-1:0];
      end
   end

   // Scale division chain: s = (m - inner) * ONE / (outer - inner)
   logic                sd_v   [W+1];
   logic [S_TAG_W-1:0]  sd_tag [W+1];
   logic [W-1:0]        sd_div [W+1];
   logic [0:0][W-1:0]   sd_rem [W+1];
   logic [0:0][W-1:0]   sd_lo  [W+1];
   logic [0:0][W-1:0]   sd_quot[W+1];

   assign sd_v[0]    = v3_ff;
   assign sd_tag[0]  = tag3_ff;
   assign sd_div[0]  = div3_ff;
   assign sd_rem[0]  = rem3_ff;
   assign sd_lo[0]   = lo3_ff;
   assign sd_quot[0] = '0;

   for (genvar k = 0; k < W; k++) begin : g_sdiv
      jrdz_div_cell #(.W(W), .LANES(1), .TAG_W(S_TAG_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (sd_v[k]),
         .in_tag   (sd_tag[k]),
         .in_div   (sd_div[k]),
         .in_rem   (sd_rem[k]),
         .in_lo    (sd_lo[k]),
         .in_quot  (sd_quot[k]),
         .out_valid(sd_v[k+1]),
         .out_tag  (sd_tag[k+1]),
         .out_div  (sd_div[k+1]),
         .out_rem  (sd_rem[k+1]),
         .out_lo   (sd_lo[k+1]),
         .out_quot (sd_quot[k+1])
      );
   end

   // Pick s, scale |x| and |y| by it
   logic [W-1:0]   x4, y4, m4, s4, ax4, ay4;
   logic           dz4;
   zone_type       zone4;
   logic [2*W-1:0] px4, py4;

   always_comb begin
      {x4, y4, m4, zone4, dz4} = sd_tag[W];
      case (zone4)
         ZONE_DEAD: s4 = '0;
         ZONE_FULL: s4 = ONE;
         default:   s4 = dz4 ? ONE : sd_quot[W][0];
      endcase
      ax4 = x4[W-1] ? W'(-x4) : x4;
      ay4 = y4[W-1] ? W'(-y4) : y4;
      px4 = ax4 * s4;
      py4 = ay4 * s4;
   end

   logic                v5_ff;
   logic [XY_TAG_W-1:0] tag5_ff;
   logic [W-1:0]        m5_ff;
   logic [2*W-1:0]      px5_ff, py5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= sd_v[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag5_ff <= {x4[W-1], y4[W-1], s4, zone4, (m4 == '0)};
         m5_ff   <= m4;
         px5_ff  <= px4;
         py5_ff  <= py4;
      end
   end

   // Vector division chain: |x|*s/m and |y|*s/m side by side
   logic                 xd_v   [W+1];
   logic [XY_TAG_W-1:0]  xd_tag [W+1];
   logic [W-1:0]         xd_div [W+1];
   logic [1:0][W-1:0]    xd_rem [W+1];
   logic [1:0][W-1:0]    xd_lo  [W+1];
   logic [1:0][W-1:0]    xd_quot[W+1];

   assign xd_v[0]    = v5_ff;
   assign xd_tag[0]  = tag5_ff;
   assign xd_div[0]  = m5_ff;
   assign xd_rem[0]  = {py5_ff[2*W-1:W], px5_ff[2*W-1:W]};
   assign xd_lo[0]   = {py5_ff[W-1:0], px5_ff[W-1:0]};
   assign xd_quot[0] = '0;

   for (genvar k = 0; k < W; k++) begin : g_xydiv
      jrdz_div_cell #(.W(W), .LANES(2), .TAG_W(XY_TAG_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (xd_v[k]),
         .in_tag   (xd_tag[k]),
         .in_div   (xd_div[k]),
         .in_rem   (xd_rem[k]),
         .in_lo    (xd_lo[k]),
         .in_quot  (xd_quot[k]),
         .out_valid(xd_v[k+1]),
         .out_tag  (xd_tag[k+1]),
         .out_div  (xd_div[k+1]),
         .out_rem  (xd_rem[k+1]),
         .out_lo   (xd_lo[k+1]),
         .out_quot (xd_quot[k+1])
      );
   end

   // Restore signs, clamp, zero the dead zone and zero radius
   logic         sx6, sy6, mz6, unused_div;
   logic [W-1:0] s6, qx6, qy6, cx6, cy6;
   zone_type     zone6;

   always_comb begin
      {sx6, sy6, s6, zone6, mz6} = xd_tag[W];
      unused_div = ^xd_div[W] ^ ^xd_rem[W] ^ ^xd_lo[W];
      qx6 = xd_quot[W][0];
      qy6 = xd_quot[W][1];
      if (zone6 == ZONE_DEAD || mz6) begin
         cx6 = '0;
         cy6 = '0;
      end else begin
         cx6 = sx6 ? W'(-qx6) : ((qx6 == ONE) ? ONE - W'(1) : qx6);
         cy6 = sy6 ? W'(-qy6) : ((qy6 == ONE) ? ONE - W'(1) : qy6);
      end
   end

   // Output register
   logic [W-1:0] rsp_x_ff, rsp_y_ff, rsp_mag_ff;
   zone_type     rsp_zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= xd_v[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_x_ff    <= cx6;
         rsp_y_ff    <= cy6;
         rsp_mag_ff  <= s6 ^ {W{unused_div & 1'b0}};
         rsp_zone_ff <= zone6;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.corrected_x         = rsp_x_ff;
   assign rsp_chan.corrected_y         = rsp_y_ff;
   assign rsp_chan.corrected_magnitude = rsp_mag_ff;
   assign rsp_chan.zone                = rsp_zone_ff;

   // Dead zone results carry no deflection
   a_dead_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zone_ff == ZONE_DEAD |->
         rsp_x_ff == '0 && rsp_y_ff == '0 && rsp_mag_ff == '0)
      else $error("dead zone result not zero");

   // Beyond the outer radius the scale is full
   a_full_scale : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zone_ff == ZONE_FULL |-> rsp_mag_ff == ONE)
      else $error("outer zone scale not full");

   // A zero scale in the band gives a zero vector
   a_band_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zone_ff == ZONE_BAND && rsp_mag_ff == '0 |->
         rsp_x_ff == '0 && rsp_y_ff == '0)
      else $error("zero scale with nonzero vector");
endmodule

`default_nettype wire

// File: bench/joystick_radial_dead_zone_unit_tb.sv
// ----------------------------------------------------------------------------
// joystick_radial_dead_zone_unit_tb
// Self-checking bench for the radial dead zone unit: directed corner samples,
// threshold sweeps and random samples under varied idling, with every result
// beat compared against an in-bench fixed-point model of the dead zone.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_radial_dead_zone_unit_tb;
   import jrdz_pkg::*;

   localparam int SB        = 16;
   localparam int LATENCY   = 3*SB+5;
   localparam int WD_LIMIT  = 20000;
   localparam logic signed [63:0] ONE = 64'sd1 <<< (SB-1);

   typedef struct packed {
      logic signed [SB-1:0] cx;
      logic signed [SB-1:0] cy;
      logic        [SB-1:0] mag;
      zone_type             zn;
   } corrected_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_INNER_THRESHOLD;
   logic [SB-1:0] csr_wdata = '0;

   jrdz_req_if #(.W(SB)) req_chan ();
   jrdz_rsp_if #(.W(SB)) rsp_chan ();

   joystick_radial_dead_zone_unit #(.SAMPLE_BITS(SB)) uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // thresholds as seen by the model
   logic [SB-1:0] inner_thr = 16'd9830;
   logic [SB-1:0] outer_thr = 16'd31130;

   corrected_type expected_q[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit failed = 0;
   int quiet_cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.raw_x = '0;
      req_chan.raw_y = '0;
      rsp_chan.ready = 1'b0;
   end

   // floored integer square root
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [SB-1:0] clamp_sample(longint v);
      if (v > ONE-1) return SB'(ONE-1);
      if (v < -ONE) return SB'(-ONE);
      return SB'(v);
   endfunction

   // corrected vector for one raw sample under current thresholds
   function automatic corrected_type dead_zone_correct(logic signed [SB-1:0] rx,
                                                       logic signed [SB-1:0] ry);
      corrected_type r;
      longint x, y, m, inn, out, s;
      x = rx;
      y = ry;
      m = longint'(int_sqrt(longint'(x*x + y*y)));
      inn = inner_thr;
      out = outer_thr;
      r = '0;
      s = 0;
      if (m < inn) begin
         r.zn = ZONE_DEAD;
      end else if (m > out) begin
         r.zn = ZONE_FULL;
         s = ONE;
         r.cx = clamp_sample((x*ONE)/m);
         r.cy = clamp_sample((y*ONE)/m);
      end else begin
         r.zn = ZONE_BAND;
         s = (out == inn) ? ONE : ((m-inn)*ONE)/(out-inn);
         if (m != 0) begin
            r.cx = clamp_sample((x*s)/m);
            r.cy = clamp_sample((y*s)/m);
         end
      end
      r.mag = SB'(s);
      return r;
   endfunction

   // receiver: random stall and result check
   always @(posedge clock) begin
      corrected_type e;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_q.size() == 0) begin
               $error("result beat with nothing expected");
               failed = 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_chan.corrected_x !== e.cx) begin
                  $error("corrected_x exp %0d got %0d", e.cx, rsp_chan.corrected_x);
                  failed = 1;
               end
               if (rsp_chan.corrected_y !== e.cy) begin
                  $error("corrected_y exp %0d got %0d", e.cy, rsp_chan.corrected_y);
                  failed = 1;
               end
               if (rsp_chan.corrected_magnitude !== e.mag) begin
                  $error("corrected_magnitude exp %0d got %0d", e.mag,
                         rsp_chan.corrected_magnitude);
                  failed = 1;
               end
               if (rsp_chan.zone !== e.zn) begin
                  $error("zone exp %0d got %0d", e.zn, rsp_chan.zone);
                  failed = 1;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on beats of either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one sample beat, with random idle ahead of it
   task automatic send_sample(logic signed [SB-1:0] rx, logic signed [SB-1:0] ry);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.raw_x <= rx;
      req_chan.raw_y <= ry;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_q.push_back(dead_zone_correct(rx, ry));
   endtask

   task automatic drain_pipe();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // one register write, then the enable is taken low again
   task automatic write_csr(csr_index_type idx, logic [SB-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_INNER_THRESHOLD) inner_thr = val;
      else outer_thr = val;
      @(posedge clock);
   endtask

   task automatic set_thresholds(logic [SB-1:0] inn, logic [SB-1:0] out);
      drain_pipe();
      write_csr(CSR_INNER_THRESHOLD, inn);
      write_csr(CSR_OUTER_THRESHOLD, out);
   endtask

   // random sample biased to land near the current thresholds
   task automatic send_random_sample();
      logic signed [SB-1:0] rx, ry;
      int r;
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) begin
         rx = SB'($urandom);
         ry = SB'($urandom);
      end else if (pick < 8) begin
         r = (pick < 6) ? inner_thr : outer_thr;
         r = r + $urandom_range(6) - 3;
         if (r > 32767) r = 32767;
         if (r < 0) r = 0;
         if ($urandom_range(1)) begin
            rx = SB'($urandom_range(r));
            ry = SB'(int_sqrt(longint'(r*r - int'(rx)*int'(rx))));
         end else begin
            ry = SB'($urandom_range(r));
            rx = SB'(int_sqrt(longint'(r*r - int'(ry)*int'(ry))));
         end
         if ($urandom_range(1)) rx = -rx;
         if ($urandom_range(1)) ry = -ry;
      end else begin
         rx = SB'($urandom_range(64) - 32);
         ry = SB'($urandom_range(64) - 32);
      end
      send_sample(rx, ry);
   endtask

   // corners, axes, saturation and zero radius under reset thresholds
   task automatic test_directed_extremes();
      send_sample(0, 0);
      send_sample(16'sh7fff, 0);
      send_sample(-16'sh8000, 0);
      send_sample(0, 16'sh7fff);
      send_sample(0, -16'sh8000);
      send_sample(-16'sh8000, -16'sh8000);
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(16'sh7fff, -16'sh8000);
      send_sample(9829, 0);
      send_sample(9830, 0);
      send_sample(31130, 0);
      send_sample(31131, 0);
      send_sample(-20000, 12000);
      send_sample(16'sh5555, -16'sh2aab);
   endtask

   task automatic test_threshold_corners();
      // zero inner: zero radius lands in the band
      set_thresholds(16'd0, 16'd20000);
      send_sample(0, 0);
      send_sample(1, 0);
      send_sample(-16'sh8000, 0);
      // equal thresholds
      set_thresholds(16'd15000, 16'd15000);
      send_sample(15000, 0);
      send_sample(0, -15000);
      send_sample(9000, 12000);
      // inner above outer: empty band
      set_thresholds(16'hffff, 16'd0);
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(0, 0);
      send_sample(-1, 0);
      // zero thresholds: only zero radius is in the band, saturation of unit vector
      set_thresholds(16'd0, 16'd0);
      send_sample(0, 0);
      send_sample(-16'sh8000, 1);
      send_sample(3, -4);
   endtask

   task automatic run_random_phase(int idle, int stall, int n,
                                   logic [SB-1:0] inn, logic [SB-1:0] out);
      set_thresholds(inn, out);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) send_random_sample();
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 200, 16'd9830, 16'd31130);
      run_random_phase(68, 0, 170, 16'd0, 16'd46341);
      run_random_phase(0, 68, 170, SB'($urandom_range(46341)), SB'($urandom_range(46341)));
      run_random_phase(36, 36, 170, 16'd46341, 16'd0);
      run_random_phase(0, 0, 150, 16'hffff, 16'hffff);
      run_random_phase(36, 36, 150, SB'($urandom_range(20000)),
                       SB'(20000 + $urandom_range(26341)));
      run_random_phase($urandom_range(68), $urandom_range(68), 110,
                       SB'($urandom), SB'($urandom));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_threshold_corners();
      test_random_traffic();
      drain_pipe();
      if (!failed)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
